// ===== src/dtfe_pkg.sv =====
// Shared types and constants for the DShot throttle frame encoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package dtfe_pkg;

    localparam int VALUE_W = 11;
    localparam int CMD_W   = 16;
    localparam int NUMER_W = 27;
    localparam int QUO_W   = 12;

    localparam logic [VALUE_W-1:0] VALUE_STOP    = 11'd0;
    localparam logic [VALUE_W-1:0] VALUE_TOP     = 11'd2047;
    localparam logic [VALUE_W-1:0] THROTTLE_LOW  = 11'd48;
    localparam logic [VALUE_W-1:0] THROTTLE_STEP = 11'd1999;
    localparam logic [CMD_W-1:0]   SPAN_RESET    = 16'd1000;
    localparam logic [3:0]         NIBBLE_MASK   = 4'hF;

    // radix-4 long division: two quotient bits per step
    localparam logic [2:0] DIV_LAST = 3'(QUO_W / 2 - 1);

    typedef enum logic [0:0] {
        CFG_TRAVEL_SPAN = 1'b0,
        CFG_INV_CSUM    = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        OP_DIRECT = 1'b0,
        OP_DIVIDE = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        BK_IDLE = 1'b0,
        BK_DIV  = 1'b1
    } bk_state_t;

    // one classified item in flight between front and back
    typedef struct packed {
        op_t                op;
        logic [VALUE_W-1:0] value;
        logic               fault;
        logic               tel;
        logic [NUMER_W-1:0] numer;
        logic [CMD_W-1:0]   den;
    } entry_t;

endpackage
`default_nettype wire

// ===== src/dtfe_front.sv =====
// Front end: accepts input transactions and classifies them.
// Depends on dtfe_pkg; forms the scaled numerator for the divider.
`default_nettype none
module dtfe_front (
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        kind,
    input  wire logic [dtfe_pkg::CMD_W-1:0]  command,
    input  wire logic                        telemetry_request,
    input  wire logic [dtfe_pkg::CMD_W-1:0]  span,
    output logic                             q_valid,
    input  wire logic                        q_ready,
    output dtfe_pkg::entry_t                 q_entry
);
    import dtfe_pkg::*;

    logic [CMD_W-1:0]   cmd_m1;
    logic [CMD_W-1:0]   den;
    logic [NUMER_W-1:0] prod;

    assign in_ready = q_ready;
    assign q_valid  = in_valid;

    assign cmd_m1 = command - 16'd1;
    assign den    = span - 16'd1;
    // (cmd-1)*1999, to which den/2 is added below; bounded below 2^27 since cmd < span
    assign prod   = NUMER_W'(cmd_m1) * NUMER_W'(THROTTLE_STEP);

    always_comb
    begin
        q_entry.op    = OP_DIRECT;
        q_entry.value = VALUE_STOP;
        q_entry.fault = 1'b0;
        q_entry.tel   = telemetry_request;
        q_entry.numer = prod + NUMER_W'(den[CMD_W-1:1]);
        q_entry.den   = den;
        if (kind)
        begin
            if (command > 16'(VALUE_TOP))
                q_entry.fault = 1'b1;
            else
                q_entry.value = command[VALUE_W-1:0];
        end
        else if (command == 16'd0)
        begin
            q_entry.value = VALUE_STOP;
        end
        else if (span <= 16'd1 || command >= span)
        begin
            q_entry.value = VALUE_TOP;
        end
        else
        begin
            q_entry.op = OP_DIVIDE;
        end
    end

endmodule
`default_nettype wire

// ===== src/dtfe_queue.sv =====
// Two-entry queue between front and back of the frame encoder.
// Depends on dtfe_pkg for the entry type.
`default_nettype none
module dtfe_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire dtfe_pkg::entry_t wr_entry,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output dtfe_pkg::entry_t      rd_entry
);
    import dtfe_pkg::*;

    entry_t     mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_entry = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule
`default_nettype wire

// ===== src/dtfe_back.sv =====
// Back end: radix-4 divider, frame assembly with checksum, output register.
// Depends on dtfe_pkg; takes classified entries from dtfe_queue.
`default_nettype none
module dtfe_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          inv_csum,
    input  wire logic                          q_valid,
    output logic                               q_ready,
    input  wire dtfe_pkg::entry_t              q_entry,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [15:0]                        frame,
    output logic [dtfe_pkg::VALUE_W-1:0]       value_sent,
    output logic                               fault_stop
);
    import dtfe_pkg::*;

    bk_state_t          st_reg, st_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [15:0]        rem_reg, rem_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [QUO_W-1:0]   low_reg, low_next;
    logic [15:0]        den_reg, den_next;
    logic [17:0]        den3_reg, den3_next;
    logic               tel_reg, tel_next;

    logic               ov_reg, ov_next;
    logic [15:0]        frame_reg, frame_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               fault_reg, fault_next;

    logic               out_free;
    logic [17:0]        trial;
    logic [17:0]        den1_x;
    logic [17:0]        den2_x;
    logic [17:0]        sub;
    logic [1:0]         digit;
    logic [15:0]        rem_step;
    logic [QUO_W-1:0]   quo_step;
    logic [VALUE_W-1:0] div_value;

    function automatic logic [15:0] build_frame(input logic [VALUE_W-1:0] v,
                                                input logic t, input logic inv);
        logic [11:0] p;
        logic [3:0]  cs;
        p  = {v, t};
        cs = p[3:0] ^ p[7:4] ^ p[11:8];
        if (inv)
            cs = ~cs & NIBBLE_MASK;
        return {p, cs};
    endfunction

    assign out_free   = !ov_reg || out_ready;
    assign out_valid  = ov_reg;
    assign frame      = frame_reg;
    assign value_sent = value_reg;
    assign fault_stop = fault_reg;

    // one radix-4 step: remainder stays below den
    assign trial  = {rem_reg, low_reg[QUO_W-1:QUO_W-2]};
    assign den1_x = {2'b00, den_reg};
    assign den2_x = {1'b0, den_reg, 1'b0};

    always_comb
    begin
        if (trial >= den3_reg)
        begin
            digit = 2'd3;
            sub   = den3_reg;
        end
        else if (trial >= den2_x)
        begin
            digit = 2'd2;
            sub   = den2_x;
        end
        else if (trial >= den1_x)
        begin
            digit = 2'd1;
            sub   = den1_x;
        end
        else
        begin
            digit = 2'd0;
            sub   = 18'd0;
        end
    end

    assign rem_step  = 16'(trial - sub);
    assign quo_step  = {quo_reg[QUO_W-3:0], digit};
    assign div_value = THROTTLE_LOW + quo_step[VALUE_W-1:0];

    always_comb
    begin
        st_next    = st_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        low_next   = low_reg;
        den_next   = den_reg;
        den3_next  = den3_reg;
        tel_next   = tel_reg;
        ov_next    = ov_reg && !out_ready;
        frame_next = frame_reg;
        value_next = value_reg;
        fault_next = fault_reg;
        q_ready    = 1'b0;

        unique case (st_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_entry.op)
                        OP_DIRECT:
                        begin
                            if (out_free)
                            begin
                                q_ready    = 1'b1;
                                ov_next    = 1'b1;
                                frame_next = build_frame(q_entry.value, q_entry.tel,
                                                         inv_csum);
                                value_next = q_entry.value;
                                fault_next = q_entry.fault;
                            end
                        end
                        OP_DIVIDE:
                        begin
                            q_ready   = 1'b1;
                            st_next   = BK_DIV;
                            cnt_next  = 3'd0;
                            rem_next  = {1'b0, q_entry.numer[NUMER_W-1:QUO_W]};
                            low_next  = q_entry.numer[QUO_W-1:0];
                            quo_next  = '0;
                            den_next  = q_entry.den;
                            den3_next = {2'b00, q_entry.den} + {1'b0, q_entry.den, 1'b0};
                            tel_next  = q_entry.tel;
                        end
                        default: ;
                    endcase
                end
            end
            BK_DIV:
            begin
                if (cnt_reg != DIV_LAST)
                begin
                    cnt_next = cnt_reg + 3'd1;
                    rem_next = rem_step;
                    quo_next = quo_step;
                    low_next = {low_reg[QUO_W-3:0], 2'b00};
                end
                else if (out_free)
                begin
                    st_next    = BK_IDLE;
                    ov_next    = 1'b1;
                    frame_next = build_frame(div_value, tel_reg, inv_csum);
                    value_next = div_value;
                    fault_next = 1'b0;
                end
            end
            default: st_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= BK_IDLE;
            cnt_reg <= 3'd0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        low_reg   <= low_next;
        den_reg   <= den_next;
        den3_reg  <= den3_next;
        tel_reg   <= tel_next;
        frame_reg <= frame_next;
        value_reg <= value_next;
        fault_reg <= fault_next;
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DIV_LAST)
        else $error("divider step count out of range");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == BK_DIV) |-> (rem_reg < den_reg))
        else $error("partial remainder not below divisor");

    a_fault_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && fault_reg) |-> (value_reg == VALUE_STOP))
        else $error("fault result carries a nonzero value");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == BK_DIV) |-> !q_ready)
        else $error("queue popped while divider busy");
`endif

endmodule
`default_nettype wire

// ===== src/dshot_throttle_frame_encoder_top.sv =====
// DShot throttle frame encoder, top level: config registers, front, queue, back.
// Depends on dtfe_pkg, dtfe_front, dtfe_queue and dtfe_back.
// Path: raw, stop and full-throttle items pass through the queue and the output
//   register; mapped travel also goes through the radix-4 divider.
// Throughput: 1 transaction per cycle for non-divided items while out_ready holds;
//   divided items wait for the single shared divider (one load plus 6 steps).
// Reset (async, active low): travel_span = 1000, inverted_checksum = 0, queue
//   and output empty.
`default_nettype none
module dshot_throttle_frame_encoder_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration write port
    input  wire logic                         cfg_we,
    input  wire logic [0:0]                   cfg_index,
    input  wire logic [15:0]                  cfg_wdata,
    // input transaction
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         kind,
    input  wire logic [dtfe_pkg::CMD_W-1:0]   command,
    input  wire logic                         telemetry_request,
    // result transaction
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [15:0]                       frame,
    output logic [dtfe_pkg::VALUE_W-1:0]      value_sent,
    output logic                              fault_stop
);
    import dtfe_pkg::*;

    logic [CMD_W-1:0] span_reg, span_next;
    logic             inv_reg, inv_next;

    logic   fq_valid, fq_ready;
    entry_t fq_entry;
    logic   qb_valid, qb_ready;
    entry_t qb_entry;

    // configuration registers; meant to be written only while the block is idle
    always_comb
    begin
        span_next = span_reg;
        inv_next  = inv_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TRAVEL_SPAN: span_next = cfg_wdata;
                CFG_INV_CSUM:    inv_next  = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg <= SPAN_RESET;
            inv_reg  <= 1'b0;
        end
        else
        begin
            span_reg <= span_next;
            inv_reg  <= inv_next;
        end
    end

    // front: classify and scale, no state of its own
    dtfe_front u_front (
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .command           (command),
        .telemetry_request (telemetry_request),
        .span              (span_reg),
        .q_valid           (fq_valid),
        .q_ready           (fq_ready),
        .q_entry           (fq_entry)
    );

    // decouples intake from the multi-cycle divider
    dtfe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_entry (fq_entry),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_entry (qb_entry)
    );

    // back: divide where needed, build frame, hold result for the consumer
    dtfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .inv_csum   (inv_reg),
        .q_valid    (qb_valid),
        .q_ready    (qb_ready),
        .q_entry    (qb_entry),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame      (frame),
        .value_sent (value_sent),
        .fault_stop (fault_stop)
    );

endmodule
`default_nettype wire
